// ===== rtl/okvm_pkg.sv =====
// shared types and codes for the ordered key-value map
package okvm_pkg;

    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int KEY_W    = 32;
    localparam int VALUE_W  = 64;

    typedef enum logic [OP_W-1:0] {
        OP_LOOKUP = 2'd0,
        OP_UPDATE = 2'd1,
        OP_DELETE = 2'd2,
        OP_NEXT   = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    // what the slot scan has seen so far
    typedef struct packed {
        logic found;       // a valid slot holds the request key
        logic free_found;  // at least one empty slot
        logic any_found;   // at least one valid slot
        logic gt_found;    // a valid key above the request key
    } t_scan_flags;

endpackage

// ===== rtl/okvm_ram.sv =====
// generic single-clock ram with one write port and one registered read port
module okvm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/okvm_scan.sv =====
// per-slot compare unit that accumulates match, free slot and minimum keys
module okvm_scan #(
    parameter int KW = 32,
    parameter int VW = 64,
    parameter int AW = 6
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_dv,
    input  logic [AW-1:0]         i_index,
    input  logic                  i_entry_valid,
    input  logic [KW-1:0]         i_entry_key,
    input  logic [VW-1:0]         i_entry_value,
    input  logic [KW-1:0]         i_req_key,
    output okvm_pkg::t_scan_flags o_flags,
    output logic [AW-1:0]         o_match_idx,
    output logic [VW-1:0]         o_match_value,
    output logic [AW-1:0]         o_free_idx,
    output logic [KW-1:0]         o_min_all,
    output logic [KW-1:0]         o_min_gt
);

    import okvm_pkg::*;

    t_scan_flags   r_flags;
    logic [AW-1:0] r_match_idx;
    logic [VW-1:0] r_match_value;
    logic [AW-1:0] r_free_idx;
    logic [KW-1:0] r_min_all;
    logic [KW-1:0] r_min_gt;

    logic hit;
    logic take_all;
    logic take_gt;

    assign hit      = i_entry_valid && (i_entry_key == i_req_key);
    assign take_all = i_entry_valid && (!r_flags.any_found || i_entry_key < r_min_all);
    assign take_gt  = i_entry_valid && (i_entry_key > i_req_key)
                      && (!r_flags.gt_found || i_entry_key < r_min_gt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else if (i_start) begin
            r_flags <= '0;
        end else if (i_dv) begin
            if (hit && !r_flags.found) begin
                r_flags.found <= 1'b1;
                r_match_idx   <= i_index;
                r_match_value <= i_entry_value;
            end
            if (!i_entry_valid && !r_flags.free_found) begin
                r_flags.free_found <= 1'b1;
                r_free_idx         <= i_index;
            end
            if (take_all) begin
                r_flags.any_found <= 1'b1;
                r_min_all         <= i_entry_key;
            end
            if (take_gt) begin
                r_flags.gt_found <= 1'b1;
                r_min_gt         <= i_entry_key;
            end
        end
    end

    assign o_flags       = r_flags;
    assign o_match_idx   = r_match_idx;
    assign o_match_value = r_match_value;
    assign o_free_idx    = r_free_idx;
    assign o_min_all     = r_min_all;
    assign o_min_gt      = r_min_gt;

endmodule

// ===== rtl/ordered_key_value_map_core.sv =====
// top level of the ordered key-value map: sequencer, slot ram and compare unit
//
// request channel: i_in_valid / o_in_ready with i_op, i_key, i_has_key, i_value.
// result channel: o_out_valid / i_out_ready with o_status, o_value_out, o_succ_key.
// ops: lookup, update (insert only if absent), delete, next key (bytewise order,
// first byte most significant, i.e. unsigned compare of the masked key).
// every request sweeps all ENTRIES slots through one compare unit, one slot
// per cycle off the registered ram read port; the slot ram port sets the rate.
// the next request is taken only once the current one has finished its sweep
// and retired its final step, so requests never overlap in the block.
// after reset the block clears every slot of the slot ram, with o_in_ready
// low, then accepts requests.
// the result sits in an output register; a new request is accepted while it
// waits, and that request holds in its final step until the receiver takes the
// older result, so a stalled receiver stalls the request side, nothing is lost.
module ordered_key_value_map_core #(
    parameter int ENTRIES     = 64,
    parameter int KEY_BYTES   = 4,
    parameter int VALUE_BYTES = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [okvm_pkg::OP_W-1:0]      i_op,
    input  logic [okvm_pkg::KEY_W-1:0]     i_key,
    input  logic                           i_has_key,
    input  logic [okvm_pkg::VALUE_W-1:0]   i_value,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [okvm_pkg::STATUS_W-1:0]  o_status,
    output logic [okvm_pkg::VALUE_W-1:0]   o_value_out,
    output logic [okvm_pkg::KEY_W-1:0]     o_succ_key
);

    import okvm_pkg::*;

    // stored key width: the key port only carries four bytes
    localparam int KW = (KEY_BYTES >= 4) ? KEY_W : KEY_BYTES * 8;
    localparam int VW = VALUE_BYTES * 8;
    localparam int WW = 1 + KW + VW;            // ram word: {valid, key, value}
    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    t_state r_state, n_state;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic           r_dv, n_dv;           // ram read data valid this cycle
    logic [AW-1:0]  r_dv_idx, n_dv_idx;

    // captured request
    t_op            r_op;
    logic [KW-1:0]  r_key;
    logic           r_has_key;
    logic [VW-1:0]  r_val;

    // result register
    logic           r_out_valid, n_out_valid;
    t_status        r_status, n_status;
    logic [VALUE_W-1:0] r_value_out, n_value_out;
    logic [KEY_W-1:0]   r_succ_key, n_succ_key;

    // ram ports
    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    logic [WW-1:0]  ram_wdata;
    logic           ram_re;
    logic [WW-1:0]  ram_rdata;

    // compare unit
    t_scan_flags    scan_flags;
    logic [AW-1:0]  scan_match_idx;
    logic [VW-1:0]  scan_match_value;
    logic [AW-1:0]  scan_free_idx;
    logic [KW-1:0]  scan_min_all;
    logic [KW-1:0]  scan_min_gt;

    logic accept;
    logic finish_go;
    logic from_key;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    // final step retires only when the result register is free
    assign finish_go  = (r_state == S_FINISH) && (!r_out_valid || i_out_ready);
    assign from_key   = r_has_key && scan_flags.found;
    assign ram_re     = (r_state == S_SCAN) && (r_cnt != CW'(ENTRIES));

    okvm_ram #(
        .WIDTH (WW),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_cnt[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    okvm_scan #(
        .KW (KW),
        .VW (VW),
        .AW (AW)
    ) u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (accept),
        .i_dv          (r_dv),
        .i_index       (r_dv_idx),
        .i_entry_valid (ram_rdata[WW-1]),
        .i_entry_key   (ram_rdata[WW-2 -: KW]),
        .i_entry_value (ram_rdata[VW-1:0]),
        .i_req_key     (r_key),
        .o_flags       (scan_flags),
        .o_match_idx   (scan_match_idx),
        .o_match_value (scan_match_value),
        .o_free_idx    (scan_free_idx),
        .o_min_all     (scan_min_all),
        .o_min_gt      (scan_min_gt)
    );

    // ram writes: clearing pass, insert into the first free slot, delete
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_cnt[AW-1:0];
        ram_wdata = '0;
        if (r_state == S_CLEAR) begin
            ram_we = 1'b1;
        end else if (finish_go) begin
            if (r_op == OP_UPDATE && !scan_flags.found && scan_flags.free_found) begin
                ram_we    = 1'b1;
                ram_waddr = scan_free_idx;
                ram_wdata = {1'b1, r_key, r_val};
            end else if (r_op == OP_DELETE && scan_flags.found) begin
                ram_we    = 1'b1;
                ram_waddr = scan_match_idx;
            end
        end
    end

    // sequencer and result forming
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_dv        = ram_re;
        n_dv_idx    = r_cnt[AW-1:0];
        n_out_valid = r_out_valid;
        n_status    = r_status;
        n_value_out = r_value_out;
        n_succ_key  = r_succ_key;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                if (r_cnt == CW'(ENTRIES - 1)) begin
                    n_state = S_IDLE;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = S_SCAN;
                    n_cnt   = '0;
                end
            end
            S_SCAN: begin
                if (ram_re) begin
                    n_cnt = r_cnt + 1'b1;
                end else if (!r_dv) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (finish_go) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    n_status    = ST_OK;
                    n_value_out = '0;
                    n_succ_key  = '0;
                    unique case (r_op)
                        OP_LOOKUP: begin
                            if (scan_flags.found) begin
                                n_value_out = VALUE_W'(scan_match_value);
                            end else begin
                                n_status = ST_NOT_FOUND;
                            end
                        end
                        OP_UPDATE: begin
                            if (!scan_flags.found && !scan_flags.free_found) begin
                                n_status = ST_FULL;
                            end
                        end
                        OP_DELETE: begin
                            n_status = ST_OK;
                        end
                        OP_NEXT: begin
                            if (from_key) begin
                                if (scan_flags.gt_found) begin
                                    n_succ_key = KEY_W'(scan_min_gt);
                                end else begin
                                    n_status = ST_NOT_FOUND;
                                end
                            end else if (scan_flags.any_found) begin
                                n_succ_key = KEY_W'(scan_min_all);
                            end else begin
                                n_status = ST_NOT_FOUND;
                            end
                        end
                        default: begin
                            n_status = ST_OK;
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cnt       <= '0;
            r_dv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_dv        <= n_dv;
            r_out_valid <= n_out_valid;
        end
        r_dv_idx    <= n_dv_idx;
        r_status    <= n_status;
        r_value_out <= n_value_out;
        r_succ_key  <= n_succ_key;
        if (accept) begin
            r_op      <= t_op'(i_op);
            r_key     <= i_key[KW-1:0];
            r_has_key <= i_has_key;
            r_val     <= i_value[VW-1:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_value_out = r_value_out;
    assign o_succ_key  = r_succ_key;

endmodule
